### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the tokenizer.
// The macros expect signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every clock edge, also during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/dtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited text tokenizer package
// Byte codes, register map and field layout shared by the tokenizer RTL.
// ----------------------------------------------------------------------------
package dtt_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int unsigned MAX_PENDING_SPACES = 255;
    localparam int unsigned PEND_LIMIT_INT =
        (MAX_PENDING_SPACES < 255) ? MAX_PENDING_SPACES : 255;
    localparam logic [7:0] PEND_LIMIT = 8'(PEND_LIMIT_INT);

    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_FIELD_DELIMITER = 2'd0,
        REG_STRIP_SPACES    = 2'd1,
        REG_DISCARD_EMPTY   = 2'd2
    } reg_index_t;

    localparam logic [7:0] DELIMITER_RESET = 8'd44;

    localparam int USER_BYTE_VALID = 0;
    localparam int USER_CELL_END   = 1;
    localparam int USER_CELL_KEPT  = 2;
    localparam int USER_ROW_END    = 3;

    typedef struct packed {
        logic       row_end;
        logic       cell_kept;
        logic       cell_end;
        logic       byte_valid;
    } result_flags_t;

endpackage

### hdl/delimited_text_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited text tokenizer unit
// Splits a byte stream into cells and rows, with optional space stripping.
// ----------------------------------------------------------------------------
// A result is registered at its byte's transfer and appears on the master side in the cycle after it.
// Throughput: one byte per cycle; the output register accepts a new result in the
// same cycle that the held one is taken, so the slave side only stalls on backpressure.
// Reset: rst_n clears the tokenizer state and the output valid flag and loads the
// register defaults (delimiter 44, stripping off, discarding off).
module delimited_text_tokenizer_unit
    import dtt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,

    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] in_byte

    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,   // [7:0] out_byte, [15:8] spaces_before
    output logic [3:0]        m_axis_tuser,   // [0] byte_valid, [1] cell_end,
                                              // [2] cell_kept, [3] row_end
    output logic              m_axis_tlast    // text_end
);
    `include "assert_macros.svh"

    logic [7:0]    delim_reg;
    logic          strip_reg;
    logic          discard_reg;

    logic          has_content_reg, has_content_next;
    logic [7:0]    pend_reg, pend_next;
    logic          after_cr_reg, after_cr_next;
    logic          after_le_reg, after_le_next;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic [7:0]    out_spaces_reg, out_spaces_next;
    result_flags_t out_flags_reg, out_flags_next;
    logic          out_text_end_reg, out_text_end_next;

    logic          res_emit;
    logic          cfg_write;
    logic          in_xfer;
    logic          strip_eff;
    logic          discard_eff;
    logic          kept;
    logic [7:0]    b;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg   <= DELIMITER_RESET;
            strip_reg   <= 1'b0;
            discard_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(paddr[3:2]))
                REG_FIELD_DELIMITER: delim_reg   <= pwdata[7:0];
                REG_STRIP_SPACES:    strip_reg   <= pwdata[0];
                REG_DISCARD_EMPTY:   discard_reg <= pwdata[0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index_t'(paddr[3:2]))
            REG_FIELD_DELIMITER: prdata = {24'd0, delim_reg};
            REG_STRIP_SPACES:    prdata = {31'd0, strip_reg};
            REG_DISCARD_EMPTY:   prdata = {31'd0, discard_reg};
            default:             prdata = 32'd0;
        endcase
    end

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        b           = s_axis_tdata;
        strip_eff   = strip_reg && (delim_reg != CH_SPACE);
        discard_eff = discard_reg || (delim_reg == CH_SPACE);
        kept        = !(discard_eff && !has_content_reg);

        has_content_next  = has_content_reg;
        pend_next         = pend_reg;
        after_cr_next     = after_cr_reg;
        after_le_next     = after_le_reg;
        res_emit          = 1'b0;
        out_byte_next     = 8'd0;
        out_spaces_next   = 8'd0;
        out_flags_next    = '0;
        out_text_end_next = 1'b0;

        if (b == CH_NUL)
        begin
            res_emit          = 1'b1;
            out_text_end_next = 1'b1;
            if (!after_le_reg)
            begin
                out_flags_next.cell_end  = 1'b1;
                out_flags_next.cell_kept = kept;
                out_flags_next.row_end   = 1'b1;
            end
            has_content_next = 1'b0;
            pend_next        = 8'd0;
            after_cr_next    = 1'b0;
            after_le_next    = 1'b0;
        end
        else if (b == CH_LF && after_cr_reg)
        begin
            after_cr_next = 1'b0;
        end
        else if (b == CH_LF || b == CH_CR)
        begin
            res_emit                 = 1'b1;
            out_flags_next.cell_end  = 1'b1;
            out_flags_next.cell_kept = kept;
            out_flags_next.row_end   = 1'b1;
            has_content_next         = 1'b0;
            pend_next                = 8'd0;
            after_cr_next            = (b == CH_CR);
            after_le_next            = 1'b1;
        end
        else
        begin
            after_cr_next = 1'b0;
            after_le_next = 1'b0;
            if (b == delim_reg)
            begin
                res_emit                 = 1'b1;
                out_flags_next.cell_end  = 1'b1;
                out_flags_next.cell_kept = kept;
                has_content_next         = 1'b0;
                pend_next                = 8'd0;
            end
            else if (strip_eff && b == CH_SPACE)
            begin
                if (has_content_reg && pend_reg < PEND_LIMIT)
                begin
                    pend_next = pend_reg + 8'd1;
                end
            end
            else
            begin
                res_emit                  = 1'b1;
                out_byte_next             = b;
                out_spaces_next           = pend_reg;
                out_flags_next.byte_valid = 1'b1;
                pend_next                 = 8'd0;
                has_content_next          = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_content_reg <= 1'b0;
            pend_reg        <= 8'd0;
            after_cr_reg    <= 1'b0;
            after_le_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                has_content_reg <= has_content_next;
                pend_reg        <= pend_next;
                after_cr_reg    <= after_cr_next;
                after_le_reg    <= after_le_next;
            end
            if (s_axis_tready)
            begin
                out_valid_reg <= in_xfer && res_emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && res_emit)
        begin
            out_byte_reg     <= out_byte_next;
            out_spaces_reg   <= out_spaces_next;
            out_flags_reg    <= out_flags_next;
            out_text_end_reg <= out_text_end_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_spaces_reg, out_byte_reg};
    assign m_axis_tuser  = out_flags_reg;
    assign m_axis_tlast  = out_text_end_reg;

    `ASSERT_RUN(a_stall_blocks_input,
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready,
        "Input taken while a stalled result is held.")
    `ASSERT_RUN(a_text_end_clears,
        (in_xfer && res_emit && out_text_end_next) |=>
            (!has_content_reg && pend_reg == 8'd0 && !after_cr_reg && !after_le_reg),
        "Tokenizer state not cleared after text end.")
    `ASSERT_RUN(a_kept_needs_end,
        (m_axis_tvalid && m_axis_tuser[USER_CELL_KEPT]) |-> m_axis_tuser[USER_CELL_END],
        "Cell reported kept without a cell end.")
    `ASSERT_RUN(a_byte_not_boundary,
        (m_axis_tvalid && m_axis_tuser[USER_BYTE_VALID]) |->
            (!m_axis_tuser[USER_CELL_END] && !m_axis_tuser[USER_ROW_END] && !m_axis_tlast),
        "Content byte flagged as a boundary.")
    `ASSERT_RUN(a_pend_limit,
        pend_reg <= PEND_LIMIT,
        "Held space count above its limit.")

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited text tokenizer unit testbench
// Streams directed and random text through the tokenizer under several
// register settings. Each byte transfer is run through a local model of the
// tokenizer, and every result transfer is compared field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module testbench
    import dtt_pkg::*;
();

    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER = 400;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] spaces_before;
        logic       byte_valid;
        logic       cell_end;
        logic       cell_kept;
        logic       row_end;
        logic       text_end;
    } token_t;

    localparam logic [7:0] DIRECTED_TEXT [20] = '{
        8'h00, 8'h41, 8'hFF, 8'h2C, 8'h2C, 8'h20, CH_CR, CH_LF, CH_CR, CH_CR,
        CH_LF, 8'h00, CH_LF, 8'h00, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h2C, 8'h00
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;
    logic [3:0]        m_axis_tuser;
    logic              m_axis_tlast;

    logic [7:0] cfg_delimiter = DELIMITER_RESET;
    logic       cfg_strip = 1'b0;
    logic       cfg_discard = 1'b0;

    logic       cell_has_content = 1'b0;
    logic [7:0] held_spaces = '0;
    logic       after_cr = 1'b0;
    logic       after_line_end = 1'b0;

    logic [7:0] text_bytes [$];
    token_t     expected_tokens [$];
    int         mismatches = 0;

    token_t     driver_token;
    int         burst_left = 0;
    int         gap_left = 0;

    token_t     wanted;
    int         tokens_seen = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    int unsigned rx_cycle = 0;

    int         idle_cycles = 0;

    delimited_text_tokenizer_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit tokenize_byte(input logic [7:0] b, output token_t tok);
        logic strip_on;
        logic discard_on;
        logic keep;
        strip_on = cfg_strip;
        discard_on = cfg_discard;
        tok = '0;
        if (cfg_delimiter == CH_SPACE)
        begin
            strip_on = 1'b0;
            discard_on = 1'b1;
        end
        keep = !(discard_on && !cell_has_content);
        if (b == CH_NUL)
        begin
            tok.text_end = 1'b1;
            if (!after_line_end)
            begin
                tok.cell_end = 1'b1;
                tok.cell_kept = keep;
                tok.row_end = 1'b1;
            end
            cell_has_content = 1'b0;
            held_spaces = '0;
            after_cr = 1'b0;
            after_line_end = 1'b0;
            return 1'b1;
        end
        if (b == CH_LF && after_cr)
        begin
            after_cr = 1'b0;
            return 1'b0;
        end
        if (b == CH_LF || b == CH_CR)
        begin
            tok.cell_end = 1'b1;
            tok.cell_kept = keep;
            tok.row_end = 1'b1;
            cell_has_content = 1'b0;
            held_spaces = '0;
            after_cr = (b == CH_CR);
            after_line_end = 1'b1;
            return 1'b1;
        end
        after_cr = 1'b0;
        after_line_end = 1'b0;
        if (b == cfg_delimiter)
        begin
            tok.cell_end = 1'b1;
            tok.cell_kept = keep;
            cell_has_content = 1'b0;
            held_spaces = '0;
            return 1'b1;
        end
        if (strip_on && b == CH_SPACE)
        begin
            if (cell_has_content && held_spaces < PEND_LIMIT)
                held_spaces = held_spaces + 8'd1;
            return 1'b0;
        end
        tok.out_byte = b;
        tok.spaces_before = held_spaces;
        tok.byte_valid = 1'b1;
        held_spaces = '0;
        cell_has_content = 1'b1;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches < 60)
                $display("%0t ns: %s expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic apb_write(input reg_index_t idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FIELD_DELIMITER: cfg_delimiter = value[7:0];
            REG_STRIP_SPACES:    cfg_strip = value[0];
            REG_DISCARD_EMPTY:   cfg_discard = value[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (text_bytes.size() != 0 || expected_tokens.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] delim, input logic strip, input logic discard);
        wait_drained();
        apb_write(REG_FIELD_DELIMITER, {24'd0, delim});
        apb_write(REG_STRIP_SPACES, {31'd0, strip});
        apb_write(REG_DISCARD_EMPTY, {31'd0, discard});
        @(negedge clk);
    endtask

    // Mostly well-formed texts closed by a zero byte, mixed with noise bursts.
    task automatic push_random_text(input int budget);
        int added;
        int pick;
        int run;
        int base;
        base = text_bytes.size();
        added = 0;
        while (added < budget)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                run = $urandom_range(1, 10);
                repeat (run) text_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                run = $urandom_range(2, 40);
                repeat (run)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 40)
                        text_bytes.push_back(8'($urandom_range(33, 126)));
                    else if (pick < 58)
                        repeat ($urandom_range(1, 4)) text_bytes.push_back(CH_SPACE);
                    else if (pick < 70)
                        text_bytes.push_back(cfg_delimiter);
                    else if (pick < 75)
                        text_bytes.push_back(CH_CR);
                    else if (pick < 80)
                        text_bytes.push_back(CH_LF);
                    else if (pick < 86)
                    begin
                        text_bytes.push_back(CH_CR);
                        text_bytes.push_back(CH_LF);
                    end
                    else if (pick < 88)
                        text_bytes.push_back(CH_NUL);
                    else
                        text_bytes.push_back(8'($urandom_range(1, 255)));
                end
                text_bytes.push_back(CH_NUL);
            end
            added = text_bytes.size() - base;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
            begin
                if (tokenize_byte(s_axis_tdata, driver_token))
                    expected_tokens.push_back(driver_token);
                void'(text_bytes.pop_front());
                if (burst_left > 0)
                    burst_left--;
            end
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (text_bytes.size() != 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= text_bytes[0];
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: no result expected, actual tdata %h tuser %h tlast %b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
                else
                begin
                    wanted = expected_tokens.pop_front();
                    check_field("out_byte", wanted.out_byte, m_axis_tdata[7:0]);
                    check_field("spaces_before", wanted.spaces_before, m_axis_tdata[15:8]);
                    check_field("byte_valid", wanted.byte_valid,
                                m_axis_tuser[USER_BYTE_VALID]);
                    check_field("cell_end", wanted.cell_end, m_axis_tuser[USER_CELL_END]);
                    check_field("cell_kept", wanted.cell_kept, m_axis_tuser[USER_CELL_KEPT]);
                    check_field("row_end", wanted.row_end, m_axis_tuser[USER_ROW_END]);
                    check_field("text_end", wanted.text_end, m_axis_tlast);
                end
                tokens_seen++;
            end
            rx_cycle++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!hold_done && tokens_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (rx_cycle[8:6])
                    3'd0, 3'd1: m_axis_tready <= 1'b1;
                    3'd2:       m_axis_tready <= 1'($urandom_range(0, 1));
                    3'd3:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    3'd4:       m_axis_tready <= rx_cycle[2];
                    default:    m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable && pwrite))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("delimited_text_tokenizer_unit: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_TEXT[i])
            text_bytes.push_back(DIRECTED_TEXT[i]);

        configure(8'd44, 1'b1, 1'b1);
        // Leading spaces, then a trailing run long enough to saturate the count.
        text_bytes.push_back(CH_SPACE);
        text_bytes.push_back(CH_SPACE);
        text_bytes.push_back(8'h61);
        repeat (270) text_bytes.push_back(CH_SPACE);
        text_bytes.push_back(8'h62);
        text_bytes.push_back(8'h2C);
        text_bytes.push_back(8'h2C);
        text_bytes.push_back(CH_NUL);
        push_random_text(135);

        configure(CH_SPACE, 1'b1, 1'b0);
        push_random_text(135);
        configure(8'd255, 1'b1, 1'b0);
        push_random_text(135);
        configure(8'd1, 1'b0, 1'b1);
        push_random_text(135);
        configure(8'd0, 1'b1, 1'b1);
        push_random_text(135);
        configure(CH_CR, 1'b1, 1'b1);
        push_random_text(135);
        configure(CH_LF, 1'b0, 1'b0);
        push_random_text(135);
        repeat (2)
        begin
            configure(8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
            push_random_text(135);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("delimited_text_tokenizer_unit: match");
        else
            $display("delimited_text_tokenizer_unit: mismatch");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/dtt_pkg.sv
hdl/delimited_text_tokenizer_unit.sv
tb/testbench.sv
